/* rtl/core/bf3_pkg.sv */
// Shared widths, register indexes and reset values of the 3x3 box filter.
package bf3_pkg;

	// Payload widths of the two channels.
	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int COL_OUT_W = 10;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd1024;
	localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd1;

	// Mean unit: a sum of up to nine pixels, a count of one to nine.
	localparam int SUM_W     = 12;
	localparam int CNT_W     = 4;
	localparam int REM_W     = 4;
	localparam int STEP_W    = 4;
	localparam int DIV_STEPS = SUM_W;

endpackage

/* rtl/core/bf3_stream_if.sv */
// Valid/ready stream interfaces for the pixel input and the result output.
interface bf3_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bf3_pkg::PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface bf3_res_if;
	logic                          valid;
	logic                          ready;
	logic [bf3_pkg::PIX_W-1:0]     smoothed_value;
	logic [bf3_pkg::ROW_W-1:0]     out_row;
	logic [bf3_pkg::COL_OUT_W-1:0] out_col;
	logic                          run_last;
	logic                          frame_last;

	modport source (output valid, output smoothed_value, output out_row, output out_col,
		output run_last, output frame_last, input ready);
	modport sink (input valid, input smoothed_value, input out_row, input out_col,
		input run_last, input frame_last, output ready);
endinterface

/* rtl/core/box_filter_3x3_edge_mean.sv */
// 3x3 box filter over a raster pixel stream, averaging only in-bounds neighbours.
//
// Usage: pixels arrive on pix_in in raster order for a frame of image_width by
// image_height pixels, both set through the write port (cfg_we, cfg_index,
// cfg_data). Any register write restarts the frame at row 0, column 0. Writes
// are to be made only while the block is idle; the block itself does not enforce this.
// Each pixel request releases zero to four results on res_out: the pixel above
// and to the left, at a row end also the pixel above, and on the last row the
// results of that row too. Every result carries its row and column; run_last
// marks the last result of a pixel and frame_last the final result of a frame.
// Sequence: a pixel passes the line store read and the window update, then each
// result it releases is accumulated over the window on one adder, found by one-bit
// restoring division, and loaded into the output register. pix_in.ready is high
// only between pixels, so a new pixel waits until the last one is done.
// A stalled receiver holds the output register; the sequencer then waits in
// front of it with the next result, and a new pixel is taken as soon as the
// last result of the previous one sits in the output register.
// Reset clears the counters, the window and the registers (width 1024, height
// 1); the line stores are not cleared.
module box_filter_3x3_edge_mean #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bf3_pix_if.sink                         pix_in,
	bf3_res_if.source                       res_out,
	input  logic                            cfg_we,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bf3_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int WCMP = (WW > bf3_pkg::IMG_W_W) ? WW : bf3_pkg::IMG_W_W;
	localparam int PW   = bf3_pkg::PIX_W;
	localparam int RW   = bf3_pkg::ROW_W;
	localparam int COLW = bf3_pkg::COL_OUT_W;
	localparam int SW   = bf3_pkg::SUM_W;
	localparam int NW   = bf3_pkg::CNT_W;
	localparam int MW   = bf3_pkg::REM_W;
	localparam int TW   = bf3_pkg::STEP_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                     state_q;
	logic [bf3_pkg::IMG_W_W-1:0]    img_w_q;
	logic [bf3_pkg::IMG_H_W-1:0]    img_h_q;
	logic [CW-1:0]                  col_cnt_q;
	logic [RW-1:0]                  row_cnt_q;
	logic [CW-1:0]                  item_x_q;
	logic [RW-1:0]                  item_y_q;
	logic [PW-1:0]                  px_q;
	logic [PW-1:0]                  above_rd_q;
	logic [PW-1:0]                  two_rd_q;
	logic [PW-1:0]                  line_above_q [MAX_WIDTH];
	logic [PW-1:0]                  line_two_above_q [MAX_WIDTH];
	logic [PW-1:0]                  win_q [3][3];
	logic [3:0]                     pend_q;
	logic [1:0]                     ci_q;
	logic [1:0]                     cj_q;
	logic [SW-1:0]                  sum_q;
	logic [NW-1:0]                  cnt_q;
	logic [MW-1:0]                  rem_q;
	logic [TW-1:0]                  step_q;
	logic                           res_val_q;
	logic [PW-1:0]                  res_pix_q;
	logic [RW-1:0]                  res_row_q;
	logic [COLW-1:0]                res_col_q;
	logic                           res_last_q;
	logic                           res_frame_q;

	logic [WCMP-1:0]                w_ext;
	logic [WCMP-1:0]                w_eff;
	logic [CW-1:0]                  last_col;
	logic [RW-1:0]                  last_row;
	logic [3:0]                     sel;
	logic                           i_min;
	logic                           j_min;
	logic                           row_ok;
	logic                           col_ok;
	logic                           cell_ok;
	logic [PW-1:0]                  cell_pix;
	logic [MW:0]                    trial;
	logic                           ge;
	logic                           out_free;
	logic                           at_row_end;
	logic                           at_last_row;

	// Effective frame size: a zero width or height acts as one, width is capped.
	always_comb begin
		w_ext = WCMP'(img_w_q);
		if (w_ext == '0) begin
			w_eff = WCMP'(1);
		end else if (w_ext > WCMP'(MAX_WIDTH)) begin
			w_eff = WCMP'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		last_col = CW'(w_eff - WCMP'(1));
		last_row = (img_h_q == '0) ? '0 : img_h_q - RW'(1);
	end

	assign at_row_end  = (col_cnt_q == last_col);
	assign at_last_row = (row_cnt_q == last_row);

	// The lowest pending result goes first: above-left, above, left, here.
	always_comb begin
		sel   = pend_q & (~pend_q + 4'd1);
		i_min = sel[2] | sel[3];
		j_min = sel[1] | sel[3];
	end

	// A window cell counts if it lies in the result's neighbourhood and in the image.
	always_comb begin
		row_ok   = (ci_q >= {1'b0, i_min}) &&
			((ci_q == 2'd2) || (ci_q == 2'd1 && item_y_q != '0) ||
			(ci_q == 2'd0 && item_y_q >= RW'(2)));
		col_ok   = (cj_q >= {1'b0, j_min}) &&
			((cj_q == 2'd2) || (cj_q == 2'd1 && item_x_q != '0) ||
			(cj_q == 2'd0 && item_x_q >= CW'(2)));
		cell_ok  = row_ok && col_ok;
		cell_pix = win_q[ci_q][cj_q];
	end

	// One step of restoring division by the cell count.
	always_comb begin
		trial = {rem_q, sum_q[SW-1]};
		ge    = (trial >= {1'b0, cnt_q});
	end

	assign out_free = !res_val_q || res_out.ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= bf3_pkg::IMG_W_RESET;
			img_h_q <= bf3_pkg::IMG_H_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bf3_pkg::REG_IMAGE_WIDTH: img_w_q <= cfg_data[bf3_pkg::IMG_W_W-1:0];
				bf3_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data[bf3_pkg::IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// Line stores: registered read in ST_READ, write back in the next state, ST_UPD.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			above_rd_q <= line_above_q[col_cnt_q];
			two_rd_q   <= line_two_above_q[col_cnt_q];
		end
		if (state_q == ST_UPD) begin
			line_above_q[col_cnt_q]     <= px_q;
			line_two_above_q[col_cnt_q] <= above_rd_q;
		end
	end

	// Window of the last three columns, shifted left as each pixel enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (state_q == ST_UPD) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= two_rd_q;
			win_q[1][2] <= above_rd_q;
			win_q[2][2] <= px_q;
		end
	end

	// Sequencer with the shared accumulator and divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			item_x_q  <= '0;
			item_y_q  <= '0;
			px_q      <= '0;
			pend_q    <= '0;
			ci_q      <= '0;
			cj_q      <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
			rem_q     <= '0;
			step_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pix_in.valid) begin
						px_q    <= pix_in.pixel_value;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					item_x_q <= col_cnt_q;
					item_y_q <= row_cnt_q;
					pend_q   <= {at_last_row && at_row_end,
						at_last_row && (col_cnt_q != '0),
						(row_cnt_q != '0) && at_row_end,
						(row_cnt_q != '0) && (col_cnt_q != '0)};
					ci_q     <= '0;
					cj_q     <= '0;
					sum_q    <= '0;
					cnt_q    <= '0;
					if ((row_cnt_q != '0 || at_last_row) &&
						(col_cnt_q != '0 || at_row_end)) begin
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
					if (at_row_end) begin
						col_cnt_q <= '0;
						row_cnt_q <= at_last_row ? '0 : row_cnt_q + RW'(1);
					end else begin
						col_cnt_q <= col_cnt_q + CW'(1);
					end
				end
				ST_SUM: begin
					sum_q <= sum_q + (cell_ok ? SW'(cell_pix) : '0);
					cnt_q <= cnt_q + NW'(cell_ok);
					if (cj_q == 2'd2) begin
						cj_q <= '0;
						ci_q <= ci_q + 2'd1;
					end else begin
						cj_q <= cj_q + 2'd1;
					end
					if (ci_q == 2'd2 && cj_q == 2'd2) begin
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q  <= ge ? MW'(trial - {1'b0, cnt_q}) : MW'(trial);
					sum_q  <= {sum_q[SW-2:0], ge};
					step_q <= step_q + TW'(1);
					if (step_q == TW'(bf3_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						pend_q <= pend_q & ~sel;
						ci_q   <= '0;
						cj_q   <= '0;
						sum_q  <= '0;
						cnt_q  <= '0;
						state_q <= ((pend_q & ~sel) == '0) ? ST_IDLE : ST_SUM;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// A register write restarts the frame.
			if (cfg_we) begin
				col_cnt_q <= '0;
				row_cnt_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_val_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			res_val_q <= 1'b1;
		end else if (res_out.ready) begin
			res_val_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			res_pix_q   <= sum_q[PW-1:0];
			res_row_q   <= i_min ? item_y_q : item_y_q - RW'(1);
			res_col_q   <= COLW'(j_min ? item_x_q : item_x_q - CW'(1));
			res_last_q  <= ((pend_q & ~sel) == '0);
			res_frame_q <= sel[3];
		end
	end

	assign pix_in.ready           = (state_q == ST_IDLE);
	assign res_out.valid          = res_val_q;
	assign res_out.smoothed_value = res_pix_q;
	assign res_out.out_row        = res_row_q;
	assign res_out.out_col        = res_col_q;
	assign res_out.run_last       = res_last_q;
	assign res_out.frame_last     = res_frame_q;

	// An accepted pixel always starts a line store read.
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> state_q == ST_READ)
		else $error("accepted pixel did not start a line store read");

	// The final result of a frame is also the last result of its pixel.
	a_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_val_q && res_frame_q |-> res_last_q)
		else $error("frame_last without run_last");

	// Division never runs with an empty neighbourhood.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("division by a zero cell count");

	// The column counter stays inside the configured row.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_cnt_q <= last_col)
		else $error("column counter beyond the row end");

	// Result work only runs while a result is pending.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUM || state_q == ST_DIV || state_q == ST_OUT |-> pend_q != '0)
		else $error("result computation with nothing pending");

endmodule

/* verif/bf3_mean_checker.sv */
// Checker for the 3x3 box filter: predicts every smoothed pixel and compares the result channel.
module bf3_mean_checker
	import bf3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bf3_pix_if                    pix,
	bf3_res_if                    res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    results_due
);

	// One smoothed pixel as it should appear on the result channel.
	typedef struct packed {
		logic [PIX_W-1:0]     smoothed;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 run_last;
		logic                 frame_last;
	} smoothed_px_t;

	smoothed_px_t awaited_pixels[$];

	// Private copy of the filter state and its two registers.
	logic [PIX_W-1:0]   above_line     [MAX_WIDTH];
	logic [PIX_W-1:0]   two_above_line [MAX_WIDTH];
	logic [PIX_W-1:0]   win            [9];
	int                 col_pos;
	int                 row_pos;
	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	int                 mismatches;

	// Floor of the mean over the in-bounds part of the neighbourhood of (r,c).
	// Window cell (i,j) holds the pixel at (y-2+i, x-2+j).
	function automatic logic [PIX_W-1:0] window_mean(int y, int x, int r, int c, int w, int h);
		int sum;
		int cnt;
		int pr;
		int pc;
		int i;
		int j;
		sum = 0;
		cnt = 0;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				pr = y - 2 + i;
				pc = x - 2 + j;
				if (pr >= r - 1 && pr <= r + 1 && pc >= c - 1 && pc <= c + 1 &&
						pr >= 0 && pr < h && pc >= 0 && pc < w) begin
					sum += int'(win[i * 3 + j]);
					cnt++;
				end
			end
		end
		return (cnt == 0) ? '0 : PIX_W'(sum / cnt);
	endfunction

	function automatic smoothed_px_t smoothed_at(int y, int x, int r, int c, int w, int h);
		smoothed_px_t px;
		px.smoothed   = window_mean(y, x, r, c, w, h);
		px.row        = ROW_W'(r);
		px.col        = COL_OUT_W'(c);
		px.run_last   = 1'b0;
		px.frame_last = (r == h - 1 && c == w - 1);
		return px;
	endfunction

	// Advance the filter by one pixel and queue the smoothed pixels it releases.
	task automatic filter_pixel(input logic [PIX_W-1:0] px);
		smoothed_px_t found [4];
		int w;
		int h;
		int x;
		int y;
		int n;
		int k;
		w = (width_reg == '0) ? 1 :
			((int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
		h = (height_reg == '0) ? 1 : int'(height_reg);
		x = (col_pos >= w) ? w - 1 : col_pos;
		y = (row_pos >= h) ? h - 1 : row_pos;
		n = 0;

		// Slide the window one column left and bring in the new column.
		for (k = 0; k < 3; k++) begin
			win[k * 3]     = win[k * 3 + 1];
			win[k * 3 + 1] = win[k * 3 + 2];
		end
		win[2] = two_above_line[x];
		win[5] = above_line[x];
		win[8] = px;
		two_above_line[x] = above_line[x];
		above_line[x]     = px;

		// The row above comes first, then the current row when it is the last one.
		if (y >= 1) begin
			if (x >= 1) begin
				found[n] = smoothed_at(y, x, y - 1, x - 1, w, h);
				n++;
			end
			if (x == w - 1) begin
				found[n] = smoothed_at(y, x, y - 1, x, w, h);
				n++;
			end
		end
		if (y == h - 1) begin
			if (x >= 1) begin
				found[n] = smoothed_at(y, x, y, x - 1, w, h);
				n++;
			end
			if (x == w - 1) begin
				found[n] = smoothed_at(y, x, y, x, w, h);
				n++;
			end
		end
		if (n > 0) found[n - 1].run_last = 1'b1;
		for (k = 0; k < n; k++) awaited_pixels.push_back(found[k]);

		// Raster position, wrapping after the last pixel of the frame.
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h) y = 0;
		end
		col_pos = x;
		row_pos = y;
	endtask

	function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Sample both channels and the write port at each rising edge.
	always @(posedge clk or negedge arst_n) begin : monitor
		int i;
		smoothed_px_t want;
		if (!arst_n) begin
			awaited_pixels.delete();
			for (i = 0; i < MAX_WIDTH; i++) begin
				above_line[i]     = '0;
				two_above_line[i] = '0;
			end
			for (i = 0; i < 9; i++) win[i] = '0;
			col_pos     = 0;
			row_pos     = 0;
			width_reg   = IMG_W_RESET;
			height_reg  = IMG_H_RESET;
			mismatches  = 0;
			fail_count  <= 0;
			results_due <= 0;
		end else begin
			// Any register write restarts the frame; stores and window are kept.
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: width_reg = cfg_data[IMG_W_W-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[IMG_H_W-1:0];
					default: ;
				endcase
				col_pos = 0;
				row_pos = 0;
			end

			// Each accepted result is held against the oldest prediction.
			if (res.valid && res.ready) begin
				if (awaited_pixels.size() == 0) begin
					$error("result for row %0d col %0d arrived with none expected",
						res.out_row, res.out_col);
					mismatches++;
				end else begin
					want = awaited_pixels.pop_front();
					mismatches += field_differs("smoothed_value", 32'(want.smoothed),
						32'(res.smoothed_value));
					mismatches += field_differs("out_row", 32'(want.row), 32'(res.out_row));
					mismatches += field_differs("out_col", 32'(want.col), 32'(res.out_col));
					mismatches += field_differs("run_last", 32'(want.run_last),
						32'(res.run_last));
					mismatches += field_differs("frame_last", 32'(want.frame_last),
						32'(res.frame_last));
				end
			end

			if (pix.valid && pix.ready) filter_pixel(pix.pixel_value);

			fail_count  <= mismatches;
			results_due <= awaited_pixels.size();
		end
	end

endmodule

/* verif/tb_box_filter_3x3_edge_mean.sv */
// Testbench top for the 3x3 box filter: pixel and register stimulus, receiver stalls, verdict.
module tb_box_filter_3x3_edge_mean;
	import bf3_pkg::*;

	localparam int MAX_WIDTH       = 1024;
	localparam int RANDOM_ITEMS    = 230;
	localparam int SETTLE_CYCLES   = 8;
	localparam int END_CYCLES      = 40;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT  = 5000;

	// Frame shapes for the random part.
	typedef enum {SHAPE_SMALL, SHAPE_COLUMN, SHAPE_OVER_WIDE, SHAPE_LONG_ROW} frame_shape_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  hold_off_wanted = 1'b0;
	int                    fail_count;
	int                    results_due;
	int                    quiet_cycles = 0;

	bf3_pix_if pix_ch();
	bf3_res_if res_ch();

	box_filter_3x3_edge_mean #(
		.MAX_WIDTH(MAX_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_ch),
		.res_out(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bf3_mean_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) mean_check (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_ch),
		.res(res_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.results_due(results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 80) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px, input bit calm);
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel_value <= px;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	task automatic send_burst(input logic [PIX_W-1:0] pixels[$]);
		foreach (pixels[i]) send_pixel(pixels[i], 1'b0);
	endtask

	// Wait until every predicted result has come, then let a silent pixel finish.
	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [CFG_DATA_W-1:0] width_data, input int h);
		write_reg(REG_IMAGE_WIDTH, width_data);
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
	endtask

	// Receiver: random stalls, calm stretches, and one long hold-off on request.
	initial begin
		int idle_left;
		bit held_off;
		bit calm;
		idle_left = 0;
		held_off  = 1'b0;
		calm      = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_wanted && !held_off) begin
				held_off  = 1'b1;
				idle_left = HOLD_OFF_CYCLES;
			end else if (idle_left == 0) begin
				idle_left = pick_gap(calm);
			end
			if (idle_left > 0) begin
				res_ch.ready <= 1'b0;
				idle_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
			if ($urandom_range(0, 199) == 0) calm = !calm;
		end
	end

	// Watchdog: too long without any transfer on either channel ends the run.
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed frames first, then random frames of several shapes.
	initial begin
		logic [PIX_W-1:0]      burst[$];
		logic [PIX_W-1:0]      px;
		logic [PIX_W-1:0]      base;
		logic [CFG_DATA_W-1:0] width_data;
		frame_shape_t          shape;
		int                    w;
		int                    h;
		int                    count;
		int                    style;
		int                    random_items;
		int                    i;
		bit                    calm;

		pix_ch.valid       <= 1'b0;
		pix_ch.pixel_value <= '0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_IMAGE_WIDTH;
		cfg_data           <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset frame is one row of 1024: each pixel after the first releases its left neighbour.
		burst = '{8'hFF, 8'h00, 8'hFF, 8'h80};
		send_burst(burst);
		drain_results();

		// Full 3x3 frame with alternating extremes, so borders and corners differ.
		set_frame(16'd3, 3);
		burst = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE, 8'h7F};
		send_burst(burst);
		drain_results();

		// Width and height of zero act as one: each pixel is a whole frame.
		set_frame(16'd0, 0);
		burst = '{8'hA5, 8'h5A};
		send_burst(burst);
		drain_results();

		// Width beyond the line store is clipped; the first row of two releases nothing.
		set_frame(16'd2047, 2);
		burst = '{8'h11, 8'hEE, 8'h33};
		send_burst(burst);
		drain_results();

		// A single register write in mid-frame restarts at row 0, column 0.
		set_frame(16'd2, 2);
		burst = '{8'h40, 8'hC0};
		send_burst(burst);
		drain_results();
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		burst = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F};
		send_burst(burst);
		drain_results();

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: shape = SHAPE_COLUMN;
				1: shape = SHAPE_OVER_WIDE;
				2: shape = SHAPE_LONG_ROW;
				default: shape = SHAPE_SMALL;
			endcase
			if (random_items == 0) shape = SHAPE_SMALL;

			case (shape)
				SHAPE_COLUMN: begin
					w     = $urandom_range(0, 1);
					h     = $urandom_range(0, 65535);
					count = $urandom_range(5, 30);
				end
				SHAPE_OVER_WIDE: begin
					w     = $urandom_range(MAX_WIDTH, 2047);
					h     = $urandom_range(0, 1);
					count = $urandom_range(20, 40);
				end
				SHAPE_LONG_ROW: begin
					w     = $urandom_range(20, 60);
					h     = $urandom_range(2, 65535);
					count = w + $urandom_range(1, 12);
				end
				default: begin
					w     = $urandom_range(1, 8);
					h     = $urandom_range(1, 6);
					count = w * h * $urandom_range(1, 2);
					if ($urandom_range(0, 2) == 0) count += $urandom_range(1, w * h);
				end
			endcase

			// The hold-off frame is a single row, so results pile up from the start.
			if (random_items == 0) begin
				h     = 1;
				count = w * 2 + 4;
			end

			// Bits above the width field are don't-care, so they are randomised.
			width_data = CFG_DATA_W'($urandom);
			width_data[IMG_W_W-1:0] = IMG_W_W'(w);
			set_frame(width_data, h);
			if (random_items == 0) hold_off_wanted <= 1'b1;

			calm  = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 3);
			base  = PIX_W'($urandom_range(0, 255));
			for (i = 0; i < count; i++) begin
				case (style)
					2: px = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
					3: px = base + PIX_W'($urandom_range(0, 3));
					default: px = PIX_W'($urandom_range(0, 255));
				endcase
				send_pixel(px, calm);
			end
			random_items += count;
			drain_results();
		end

		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
